// File: rtl/core/lpis_pkg.sv
// ----------------------------------------------------------------------------
// lpis_pkg : shared types and constants of the linear-probe identity set
// Widths of the request and response fields, command and status codes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package lpis_pkg;

   // Table sizing
   localparam int MAX_SLOTS_DEF = 1024;   // default for the top-level parameter
   localparam int TABLE_LIMIT   = 1024;   // largest capacity the register selects

   // Field widths
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 11;
   localparam int COUNT_W  = 11;
   localparam int LOG2_W   = 4;

   // Capacity register limits
   localparam logic [LOG2_W-1:0] LOG2_MIN   = 4'd3;
   localparam logic [LOG2_W-1:0] LOG2_MAX   = 4'd10;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
   localparam logic [SLOT_W-1:0]  NO_SLOT   = 11'h7FF;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

   // Sequencer states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

endpackage

// File: rtl/core/lpis_if.sv
// ----------------------------------------------------------------------------
// lpis_req_if / lpis_rsp_if : valid/ready channels of the identity set
// Request channel carries command, key and hash; response channel carries
// the outcome of one request.
// ----------------------------------------------------------------------------
interface lpis_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpis_pkg::CMD_W-1:0]    command;
   logic [lpis_pkg::KEY_W-1:0]    key;
   logic [lpis_pkg::HASH_W-1:0]   key_hash;

   modport source (output valid, output command, output key, output key_hash,
                   input ready);
   modport sink   (input valid, input command, input key, input key_hash,
                   output ready);
endinterface

interface lpis_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lpis_pkg::STATUS_W-1:0]  status;
   logic                           found;
   logic signed [lpis_pkg::SLOT_W-1:0] slot_index;
   logic [lpis_pkg::KEY_W-1:0]     found_key;
   logic [lpis_pkg::COUNT_W-1:0]   entry_total;
   logic                           needs_growth;

   modport source (output valid, output status, output found, output slot_index,
                   output found_key, output entry_total, output needs_growth,
                   input ready);
   modport sink   (input valid, input status, input found, input slot_index,
                   input found_key, input entry_total, input needs_growth,
                   output ready);
endinterface

// File: rtl/core/lpis_ram.sv
// ----------------------------------------------------------------------------
// lpis_ram : generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lpis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/linear_probe_identity_set.sv
// ----------------------------------------------------------------------------
// linear_probe_identity_set : open-addressing hash set with linear probing
// Stores 64-bit keys in a power-of-two slot table; insert, lookup and scan
// walk forward from the hashed slot one slot per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Contents
//  req_ch   in   valid/ready          command, key, key_hash
//  rsp_ch   out  valid/ready          status, found, slot_index, found_key,
//                                     entry_total, needs_growth
//  csr_*    in   csr_we (no ready)    log2_slots in csr_wdata
//
//  After reset a clearing pass over all min(MAX_SLOTS, 1024) slots empties
//  the valid store; requests are held off until it ends.
//  A request probes P slots (1 .. capacity); the probe loop reads one slot
//  a cycle through the single read port of the key and valid RAMs. An
//  unknown command skips the probe and goes straight to S_DONE.
//  The response sits in an output register, so a new request is taken while
//  the previous result still waits; a stalled response holds only the final
//  step of the next request.
//  Reset is synchronous and active high.
//
module linear_probe_identity_set #(
   parameter int MAX_SLOTS = lpis_pkg::MAX_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lpis_req_if.sink                      req_ch,
   lpis_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [lpis_pkg::LOG2_W-1:0]   csr_wdata
);

   // Physical table depth: the register never selects more than TABLE_LIMIT.
   localparam int DEPTH = (MAX_SLOTS < lpis_pkg::TABLE_LIMIT) ? MAX_SLOTS
                                                              : lpis_pkg::TABLE_LIMIT;
   localparam int AW    = $clog2(DEPTH);

   // Sequencer and control state
   lpis_pkg::state_type              state_ff, state_in;
   logic [AW-1:0]                    clr_ff, clr_in;
   logic [lpis_pkg::LOG2_W-1:0]      log2_ff, log2_in;
   logic [lpis_pkg::COUNT_W-1:0]     count_ff, count_in;

   // Request held during the probe
   logic [lpis_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [lpis_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [AW-1:0]                    pos_ff, pos_in;
   logic [lpis_pkg::SLOT_W-1:0]      probe_ff, probe_in;

   // Outcome waiting to be loaded into the response register
   logic [lpis_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                             res_found_ff, res_found_in;
   logic [lpis_pkg::SLOT_W-1:0]      res_slot_ff, res_slot_in;

   // Response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lpis_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [lpis_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [lpis_pkg::KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [lpis_pkg::COUNT_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                             rsp_growth_ff, rsp_growth_in;

   // Capacity derived from the register
   logic [lpis_pkg::LOG2_W-1:0]      log2_eff;
   logic [lpis_pkg::SLOT_W-1:0]      cap;
   logic [lpis_pkg::SLOT_W-1:0]      thresh;
   logic [AW-1:0]                    mask;

   // RAM ports
   logic [AW-1:0]                    rd_addr;
   logic [lpis_pkg::KEY_W-1:0]       key_rd;
   logic                             vld_rd;
   logic                             key_we;
   logic                             vld_we;
   logic [AW-1:0]                    vld_waddr;
   logic                             vld_wdata;

   // Probe decode
   logic                             req_take;
   logic                             cmd_known;
   logic                             out_free;
   logic [AW-1:0]                    pos_next;
   logic [lpis_pkg::SLOT_W-1:0]      probe_next;
   logic                             slot_empty;
   logic                             slot_hit;
   logic                             walk_done;
   logic                             probe_stop;

   // -------------------------------------------------------------------------
   // Capacity: saturate the register to 3..10, limit to the table depth.
   // Three quarters of a power of two of at least 8 is cap - cap/4.
   // -------------------------------------------------------------------------
   always_comb begin
      log2_eff = log2_ff;
      if (log2_ff < lpis_pkg::LOG2_MIN) begin
         log2_eff = lpis_pkg::LOG2_MIN;
      end else if (log2_ff > lpis_pkg::LOG2_MAX) begin
         log2_eff = lpis_pkg::LOG2_MAX;
      end
      cap = lpis_pkg::SLOT_W'(1) << log2_eff;
      if (cap > lpis_pkg::SLOT_W'(DEPTH)) begin
         cap = lpis_pkg::SLOT_W'(DEPTH);
      end
      mask   = AW'(cap - lpis_pkg::SLOT_W'(1));
      thresh = cap - (cap >> 2);
   end

   // -------------------------------------------------------------------------
   // Probe decode: read data in S_PROBE belongs to the slot at pos_ff.
   // -------------------------------------------------------------------------
   assign req_take   = req_ch.valid && req_ch.ready;
   assign cmd_known  = req_ch.command inside {lpis_pkg::CMD_INSERT, lpis_pkg::CMD_LOOKUP,
                                              lpis_pkg::CMD_SCAN};
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign pos_next   = (pos_ff + AW'(1)) & mask;
   assign probe_next = probe_ff + lpis_pkg::SLOT_W'(1);
   assign slot_empty = !vld_rd;
   assign slot_hit   = vld_rd && (key_rd == key_ff);
   assign walk_done  = (probe_next == cap);
   assign probe_stop = slot_empty || slot_hit || walk_done;

   // -------------------------------------------------------------------------
   // Next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpis_pkg::S_CLEAR: begin
            // advance once the last slot has been emptied
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = lpis_pkg::S_IDLE;
            end
         end
         lpis_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = cmd_known ? lpis_pkg::S_PROBE : lpis_pkg::S_DONE;
            end
         end
         lpis_pkg::S_PROBE: begin
            if (probe_stop) begin
               state_in = lpis_pkg::S_DONE;
            end
         end
         lpis_pkg::S_DONE: begin
            // hold until the response register is free
            if (out_free) begin
               state_in = lpis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lpis_pkg::S_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer outputs: handshake and RAM control
   // -------------------------------------------------------------------------
   always_comb begin
      req_ch.ready = 1'b0;
      rd_addr      = pos_ff;
      key_we       = 1'b0;
      vld_we       = 1'b0;
      vld_waddr    = pos_ff;
      vld_wdata    = 1'b0;
      case (state_ff)
         lpis_pkg::S_CLEAR: begin
            vld_we    = 1'b1;
            vld_waddr = clr_ff;
         end
         lpis_pkg::S_IDLE: begin
            // issue the first read straight from the request hash
            req_ch.ready = 1'b1;
            rd_addr      = AW'(req_ch.key_hash) & mask;
         end
         lpis_pkg::S_PROBE: begin
            rd_addr = pos_next;
            // store a new key in the first empty slot
            if (slot_empty && (cmd_ff == lpis_pkg::CMD_INSERT)) begin
               key_we    = 1'b1;
               vld_we    = 1'b1;
               vld_wdata = 1'b1;
            end
         end
         lpis_pkg::S_DONE: begin
            rd_addr = pos_ff;
         end
         default: begin
            rd_addr = pos_ff;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Datapath next values
   // -------------------------------------------------------------------------
   always_comb begin
      clr_in        = clr_ff;
      log2_in       = log2_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      probe_in      = probe_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_growth_in = rsp_growth_ff;

      if (csr_we) begin
         log2_in = csr_wdata;
      end

      // drop the response once it has been taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lpis_pkg::S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         lpis_pkg::S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_ch.command;
               key_in        = req_ch.key;
               pos_in        = AW'(req_ch.key_hash) & mask;
               probe_in      = '0;
               res_status_in = lpis_pkg::ST_IGNORED;
               res_found_in  = 1'b0;
               res_slot_in   = lpis_pkg::NO_SLOT;
            end
         end
         lpis_pkg::S_PROBE: begin
            pos_in   = pos_next;
            probe_in = probe_next;
            if (slot_empty) begin
               res_slot_in = lpis_pkg::SLOT_W'(pos_ff);
               if (cmd_ff == lpis_pkg::CMD_INSERT) begin
                  res_status_in = lpis_pkg::ST_INSERTED;
                  res_found_in  = 1'b1;
                  if (count_ff != lpis_pkg::COUNT_MAX) begin
                     count_in = count_ff + lpis_pkg::COUNT_W'(1);
                  end
               end else begin
                  res_status_in = lpis_pkg::ST_ABSENT;
                  res_found_in  = 1'b0;
               end
            end else if (slot_hit) begin
               res_slot_in   = lpis_pkg::SLOT_W'(pos_ff);
               res_status_in = lpis_pkg::ST_FOUND;
               res_found_in  = 1'b1;
            end else if (walk_done) begin
               // every slot visited, no match and no room
               res_slot_in   = lpis_pkg::NO_SLOT;
               res_found_in  = 1'b0;
               res_status_in = (cmd_ff == lpis_pkg::CMD_INSERT) ? lpis_pkg::ST_REFUSED
                                                                : lpis_pkg::ST_ABSENT;
            end
         end
         lpis_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_key_in    = res_found_ff ? key_ff : '0;
               rsp_total_in  = count_ff;
               rsp_growth_in = (count_ff >= thresh);
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpis_pkg::S_CLEAR;
         clr_ff       <= '0;
         log2_ff      <= lpis_pkg::LOG2_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         log2_ff      <= log2_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_growth_ff <= rsp_growth_in;
   end

   // -------------------------------------------------------------------------
   // Slot stores: keys are never cleared, valid bits are swept after reset.
   // -------------------------------------------------------------------------
   lpis_ram #(
      .WIDTH (lpis_pkg::KEY_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (pos_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lpis_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_we),
      .wr_addr (vld_waddr),
      .wr_data (vld_wdata),
      .rd_addr (rd_addr),
      .rd_data (vld_rd)
   );

   // -------------------------------------------------------------------------
   // Response channel
   // -------------------------------------------------------------------------
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.slot_index   = rsp_slot_ff;
   assign rsp_ch.found_key    = rsp_key_ff;
   assign rsp_ch.entry_total  = rsp_total_ff;
   assign rsp_ch.needs_growth = rsp_growth_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpis_pkg::S_CLEAR) |-> !req_ch.ready)
      else $error("request accepted during clearing pass");

   a_probe_within_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpis_pkg::S_PROBE) |-> (probe_ff < cap))
      else $error("probe walked past the table capacity");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff >= $past(count_ff)))
      else $error("entry count decreased");

   a_key_write_is_insert: assert property (@(posedge clock) disable iff (reset)
      key_we |=> (count_ff == $past(count_ff) + lpis_pkg::COUNT_W'(1)) ||
                 ($past(count_ff) == lpis_pkg::COUNT_MAX))
      else $error("key stored without counting a new entry");

   a_found_has_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_slot_ff != lpis_pkg::NO_SLOT))
      else $error("found response without a slot");

endmodule
